@@ src/sdqw_pkg.sv @@
// Package with shared constants and the quarter-wave sine table generator.
`timescale 1ns / 1ps

package sdqw_pkg;

    // Width of the phase accumulator word.
    localparam int PHASE_W = 32;

    // pi/2 in Q60 fixed point.
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

    // Number of Taylor terms after the first one.
    localparam int TAYLOR_TERMS = 12;

    // Returns (a * b) >> 60 for operands below 2^62, kept to 64 bits.
    function automatic logic [63:0] sdqw_mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = 128'(a) * 128'(b);
        return prod[123:60];
    endfunction

    // Sine of x for 0 <= x <= pi/2, argument and result in Q60.
    function automatic logic [63:0] sdqw_sin_q60(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic        subtract;
        x2       = sdqw_mul_q60(x, x);
        term     = x;
        acc      = x;
        subtract = 1'b1;
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = sdqw_mul_q60(term, x2) / 64'((2 * k) * (2 * k + 1));
            if (subtract) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
            subtract = !subtract;
        end
        return acc;
    endfunction

    // Table entry idx: round(amp * sin(pi * idx / 2^(tab_bits+1))), clamped to amp.
    function automatic logic [63:0] sdqw_rom_entry(input int unsigned idx,
                                                   input int unsigned tab_bits,
                                                   input int unsigned smp_bits);
        logic [63:0] coarse;
        logic [63:0] fine;
        logic [63:0] x;
        logic [63:0] amp;
        logic [63:0] v;
        coarse = HALF_PI_Q60 >> tab_bits;
        fine   = HALF_PI_Q60 & ((64'd1 << tab_bits) - 64'd1);
        x      = coarse * 64'(idx) + ((fine * 64'(idx)) >> tab_bits);
        amp    = (64'd1 << (smp_bits - 1)) - 64'd1;
        v      = ((sdqw_sin_q60(x) >> 20) * amp + (64'd1 << 39)) >> 40;
        if (v > amp) begin
            v = amp;
        end
        return v;
    endfunction

endpackage

@@ src/sdqw_ifs.sv @@
// Valid/ready stream interfaces for the phase input and the sine output.
`timescale 1ns / 1ps

interface sdqw_phase_if;
    import sdqw_pkg::*;

    logic               valid;
    logic               ready;
    logic [PHASE_W-1:0] phase;

    modport source (output valid, output phase, input ready);
    modport sink   (input valid, input phase, output ready);
endinterface

interface sdqw_sine_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sine_value;

    modport source (output valid, output sine_value, input ready);
    modport sink   (input valid, input sine_value, output ready);
endinterface

@@ src/sdqw_ram.sv @@
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module sdqw_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 1025,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port and both read ports share one clock; reads hold when not enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ src/sdqw_fill.sv @@
// Loads the quarter-wave sine table into the RAM, one entry per cycle after reset.
`timescale 1ns / 1ps

module sdqw_fill #(
    parameter int TABLE_BITS = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    output logic                   o_we,
    output logic [TABLE_BITS:0]    o_addr,
    output logic [SAMPLE_BITS-2:0] o_data,
    output logic                   o_done
);
    import sdqw_pkg::*;

    localparam int DEPTH  = (1 << TABLE_BITS) + 1;
    localparam int ADDR_W = TABLE_BITS + 1;
    localparam int ROM_W  = SAMPLE_BITS - 1;

    // Table contents, computed when the design is elaborated.
    logic [ROM_W-1:0] w_init [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_init
        assign w_init[g] = ROM_W'(sdqw_rom_entry(g, TABLE_BITS, SAMPLE_BITS));
    end

    logic [ADDR_W-1:0] r_cnt;
    logic              r_busy;

    // Sweep counter: runs from the first to the last entry, then stops.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (r_cnt == ADDR_W'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + ADDR_W'(1);
            end
        end
    end

    assign o_we   = r_busy;
    assign o_addr = r_cnt;
    assign o_data = w_init[r_cnt];
    assign o_done = !r_busy;

endmodule

@@ src/sdqw_interp.sv @@
// Phase decode, table read and linear interpolation pipeline.
`timescale 1ns / 1ps

module sdqw_interp #(
    parameter int TABLE_BITS = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_enable,
    sdqw_phase_if.sink             i_phase_if,
    sdqw_sine_if.source            o_sine_if,
    output logic                   o_rd_en,
    output logic [TABLE_BITS:0]    o_rd_addr_a,
    output logic [TABLE_BITS:0]    o_rd_addr_b,
    input  logic [SAMPLE_BITS-2:0] i_rd_data_a,
    input  logic [SAMPLE_BITS-2:0] i_rd_data_b
);
    import sdqw_pkg::*;

    localparam int ADDR_W  = TABLE_BITS + 1;
    localparam int ROM_W   = SAMPLE_BITS - 1;
    localparam int FRACT_W = PHASE_W - TABLE_BITS - 2;
    localparam int PROD_W  = SAMPLE_BITS + FRACT_W + 1;
    localparam int TAB_N   = 1 << TABLE_BITS;

    // Pipeline advance: a stage moves on when the stage after it is empty or moving.
    logic w_adv1;
    logic w_adv2;
    logic w_adv3;
    logic w_accept;

    logic r_v1;
    logic r_v2;
    logic r_v3;

    assign w_adv3   = !r_v3 || o_sine_if.ready;
    assign w_adv2   = !r_v2 || w_adv3;
    assign w_adv1   = !r_v1 || w_adv2;
    assign w_accept = i_phase_if.valid && i_phase_if.ready;

    assign i_phase_if.ready = i_enable && w_adv1;

    // Address decode: mirror the index in the odd quadrant and read the neighbor downward.
    logic [TABLE_BITS-1:0] w_idx;
    logic                  w_half;
    logic [ADDR_W-1:0]     w_addr_a;
    logic [ADDR_W-1:0]     w_addr_b;

    assign w_idx  = i_phase_if.phase[PHASE_W-3 -: TABLE_BITS];
    assign w_half = i_phase_if.phase[PHASE_W-2];

    always_comb begin
        if (w_half) begin
            w_addr_a = ADDR_W'(TAB_N) - {1'b0, w_idx};
            w_addr_b = w_addr_a - ADDR_W'(1);
        end else begin
            w_addr_a = {1'b0, w_idx};
            w_addr_b = w_addr_a + ADDR_W'(1);
        end
    end

    assign o_rd_en     = w_adv1;
    assign o_rd_addr_a = w_addr_a;
    assign o_rd_addr_b = w_addr_b;

    // Stage one sidebands: fraction and sign travel alongside the table read.
    logic [FRACT_W-1:0] r_fract1;
    logic               r_sign1;

    // Stage two: difference times fraction.
    logic signed [SAMPLE_BITS-1:0] w_diff;
    logic signed [PROD_W-1:0]      w_prod;
    logic signed [PROD_W-1:0]      r_prod2;
    logic [ROM_W-1:0]              r_f0_2;
    logic                          r_sign2;

    assign w_diff = $signed({1'b0, i_rd_data_b}) - $signed({1'b0, i_rd_data_a});
    assign w_prod = PROD_W'(w_diff * $signed({1'b0, r_fract1}));

    // Stage three: round half up, add to the first entry, apply the sign.
    logic signed [PROD_W-1:0]  w_round;
    logic signed [PROD_W-1:0]  w_delta;
    logic [SAMPLE_BITS-1:0]    w_mag;
    logic [SAMPLE_BITS-1:0]    w_res;
    logic [SAMPLE_BITS-1:0]    r_out;

    assign w_round = r_prod2 + $signed(PROD_W'(1) << (FRACT_W - 1));
    assign w_delta = w_round >>> FRACT_W;
    assign w_mag   = {1'b0, r_f0_2} + w_delta[SAMPLE_BITS-1:0];
    assign w_res   = r_sign2 ? (SAMPLE_BITS'(0) - w_mag) : w_mag;

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= w_accept;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Payload registers of the three stages.
    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_fract1 <= i_phase_if.phase[FRACT_W-1:0];
            r_sign1  <= i_phase_if.phase[PHASE_W-1];
        end
        if (w_adv2) begin
            r_prod2 <= w_prod;
            r_f0_2  <= i_rd_data_a;
            r_sign2 <= r_sign1;
        end
        if (w_adv3) begin
            r_out <= w_res;
        end
    end

    assign o_sine_if.valid      = r_v3;
    assign o_sine_if.sine_value = $signed(r_out);

endmodule

@@ src/sine_dds_quarter_wave_unit.sv @@
// Quarter-wave DDS sine unit: an accepted phase item is registered in stages one to three.
// Throughput is one item per cycle while the output is not stalled, set by the two-read-port
// table RAM and the 3-stage pipeline. After reset the table RAM is loaded with all
// 2^TABLE_BITS + 1 entries (1025 at the default), during which no item is accepted;
// pipeline valid bits clear on reset. Reset is synchronous and active low.
`timescale 1ns / 1ps

module sine_dds_quarter_wave_unit #(
    parameter int TABLE_BITS = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sdqw_phase_if.sink   i_phase_if,
    sdqw_sine_if.source  o_sine_if
);

    localparam int DEPTH  = (1 << TABLE_BITS) + 1;
    localparam int ADDR_W = TABLE_BITS + 1;
    localparam int ROM_W  = SAMPLE_BITS - 1;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [ROM_W-1:0]  w_wdata;
    logic              w_done;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr_a;
    logic [ADDR_W-1:0] w_raddr_b;
    logic [ROM_W-1:0]  w_rdata_a;
    logic [ROM_W-1:0]  w_rdata_b;

    // Table loader that runs once after reset.
    sdqw_fill #(
        .TABLE_BITS  (TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_we    (w_we),
        .o_addr  (w_waddr),
        .o_data  (w_wdata),
        .o_done  (w_done)
    );

    // Quarter-wave sine table.
    sdqw_ram #(
        .WIDTH  (ROM_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_re),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // Interpolation pipeline.
    sdqw_interp #(
        .TABLE_BITS  (TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_interp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (w_done),
        .i_phase_if  (i_phase_if),
        .o_sine_if   (o_sine_if),
        .o_rd_en     (w_re),
        .o_rd_addr_a (w_raddr_a),
        .o_rd_addr_b (w_raddr_b),
        .i_rd_data_a (w_rdata_a),
        .i_rd_data_b (w_rdata_b)
    );

endmodule
